@@ design/mpgr_pkg.sv @@
// Shared types and constants of the Morse pulse/gap receiver.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package mpgr_pkg;

  // Timing counter, saturating.
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Letter storage.
  localparam int MAX_ELEMENTS = 7;
  localparam int ELEM_CAP = (MAX_ELEMENTS > 7) ? 7 : MAX_ELEMENTS;
  localparam int ELEM_W = 7;
  localparam int LEN_W = 3;

  // Frame item count.
  localparam int FRAME_CAPACITY = 63;
  localparam int ITEMS_W = $clog2(FRAME_CAPACITY + 1);

  // Result kinds.
  localparam logic [1:0] KIND_LETTER = 2'd0;
  localparam logic [1:0] KIND_SPACE = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // Configuration register map.
  localparam int NUM_REGS = 5;
  localparam int DATA_W = 32;
  localparam int REG_W = 16;
  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int PADDR_W = IDX_W + 2;
  localparam logic [IDX_W-1:0] REG_MIN_PULSE = 3'd0;
  localparam logic [IDX_W-1:0] REG_DOT_DASH = 3'd1;
  localparam logic [IDX_W-1:0] REG_ELEM_GAP = 3'd2;
  localparam logic [IDX_W-1:0] REG_WORD_GAP = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRAME_END = 3'd4;

  localparam logic [REG_W-1:0] RST_MIN_PULSE = 16'd50;
  localparam logic [REG_W-1:0] RST_DOT_DASH = 16'd200;
  localparam logic [REG_W-1:0] RST_ELEM_GAP = 16'd200;
  localparam logic [REG_W-1:0] RST_WORD_GAP = 16'd500;
  localparam logic [REG_W-1:0] RST_FRAME_END = 16'd1500;

  // Queue between classifier and result side.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int RES_CNT_W = 2;

  typedef struct packed {
    logic [REG_W-1:0] min_pulse_ms;
    logic [REG_W-1:0] dot_dash_limit_ms;
    logic [REG_W-1:0] element_gap_max_ms;
    logic [REG_W-1:0] word_gap_limit_ms;
    logic [REG_W-1:0] frame_end_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ELEM_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } result_t;

  // All words produced by one sample; res0 goes out first.
  typedef struct packed {
    logic [RES_CNT_W-1:0] cnt;
    result_t              res0;
    result_t              res1;
  } entry_t;

endpackage

@@ design/morse_pulse_gap_receiver_top.sv @@
// Top level of the Morse pulse/gap receiver: configuration registers,
// classifying front end, entry queue and word-serializing back end.
// Depends on mpgr_pkg, mpgr_regs, mpgr_front, mpgr_fifo and mpgr_back.
`timescale 1ns / 1ps

// The receiver takes one line sample per clock cycle (push while full is
// low) and updates its edge timer and letter state in that same cycle. Each
// sample yields zero, one or two result words; they are queued as one entry
// in a four-entry queue, and the result side hands out one word per cycle
// while pop is high, so a sample with two words holds the result port for
// two pops. full rises only when four entries wait, i.e. when the consumer
// falls behind. There is no start-up sweep; sampling starts as reset ends.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16 and
// should be written only while the queue is empty and no sample is arriving.

module morse_pulse_gap_receiver_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpgr_pkg::PADDR_W-1:0] paddr,
  input  logic [mpgr_pkg::DATA_W-1:0]  pwdata,
  output logic [mpgr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic                         line_high_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   kind_o,
  output logic [mpgr_pkg::ELEM_W-1:0]  pattern_bits_o,
  output logic [mpgr_pkg::LEN_W-1:0]   pattern_len_o,
  output logic                         last_o
);
  import mpgr_pkg::*;

  cfg_t   cfg;
  entry_t wr_entry, head;
  logic   accept, fifo_wr, fifo_rd, fifo_empty;

  assign accept = push & ~full;

  mpgr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mpgr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .line_high_i (line_high_i),
    .accept_i    (accept),
    .wr_o        (fifo_wr),
    .entry_o     (wr_entry)
  );

  mpgr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fifo_wr),
    .wdata_i (wr_entry),
    .rd_i    (fifo_rd),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (fifo_empty)
  );

  mpgr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .fifo_empty_i   (fifo_empty),
    .rd_o           (fifo_rd),
    .pop            (pop),
    .empty          (empty),
    .kind_o         (kind_o),
    .pattern_bits_o (pattern_bits_o),
    .pattern_len_o  (pattern_len_o),
    .last_o         (last_o)
  );

endmodule

@@ design/mpgr_regs.sv @@
// APB-style configuration registers of the Morse pulse/gap receiver.
// Depends on mpgr_pkg.
`timescale 1ns / 1ps

module mpgr_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpgr_pkg::PADDR_W-1:0] paddr,
  input  logic [mpgr_pkg::DATA_W-1:0]  pwdata,
  output logic [mpgr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output mpgr_pkg::cfg_t               cfg_o
);
  import mpgr_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic [IDX_W-1:0] idx;
  logic wr_en;
  logic [REG_W-1:0] rd_val;

  assign idx = paddr[PADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MIN_PULSE: cfg_d.min_pulse_ms = pwdata[REG_W-1:0];
        REG_DOT_DASH: cfg_d.dot_dash_limit_ms = pwdata[REG_W-1:0];
        REG_ELEM_GAP: cfg_d.element_gap_max_ms = pwdata[REG_W-1:0];
        REG_WORD_GAP: cfg_d.word_gap_limit_ms = pwdata[REG_W-1:0];
        REG_FRAME_END: cfg_d.frame_end_ms = pwdata[REG_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_PULSE: rd_val = cfg_q.min_pulse_ms;
      REG_DOT_DASH: rd_val = cfg_q.dot_dash_limit_ms;
      REG_ELEM_GAP: rd_val = cfg_q.element_gap_max_ms;
      REG_WORD_GAP: rd_val = cfg_q.word_gap_limit_ms;
      REG_FRAME_END: rd_val = cfg_q.frame_end_ms;
      default: rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W - REG_W){1'b0}}, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse_ms <= RST_MIN_PULSE;
      cfg_q.dot_dash_limit_ms <= RST_DOT_DASH;
      cfg_q.element_gap_max_ms <= RST_ELEM_GAP;
      cfg_q.word_gap_limit_ms <= RST_WORD_GAP;
      cfg_q.frame_end_ms <= RST_FRAME_END;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/mpgr_front.sv @@
// Front end: tracks line level and edge timing, classifies pulses and gaps,
// and builds the words produced by each sample. Depends on mpgr_pkg.
`timescale 1ns / 1ps

module mpgr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpgr_pkg::cfg_t   cfg_i,
  input  logic             line_high_i,
  input  logic             accept_i,
  output logic             wr_o,
  output mpgr_pkg::entry_t entry_o
);
  import mpgr_pkg::*;

  logic               prev_q, prev_d;
  logic [CNT_W-1:0]   since_q, since_d;
  logic               fo_q, fo_d;
  logic [ELEM_W-1:0]  bits_q, bits_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [ITEMS_W-1:0] items_q, items_d;
  logic               pws_q, pws_d;

  logic [CNT_W-1:0]   count, since1;
  logic               lvl_change, gap_end, pulse_end;
  logic               fo1, pws1;
  logic [ELEM_W-1:0]  bits1;
  logic [LEN_W-1:0]   len1;
  logic [ITEMS_W-1:0] items1, items2, items3;
  logic               pws2, pws3;
  logic               gap_fire, end_fire, flush_on, add_space, do_end;
  logic               let_em, sp_em, end_em;
  result_t            letter_r, second_r;

  assign count = (since_q == CNT_MAX) ? since_q : since_q + 1'b1;
  assign lvl_change = line_high_i ^ prev_q;
  assign gap_end = lvl_change & prev_q;
  assign pulse_end = lvl_change & ~prev_q;
  assign since1 = lvl_change ? '0 : count;

  // A finished low pulse opens a frame if needed and may add an element.
  always_comb begin
    fo1 = fo_q;
    bits1 = bits_q;
    len1 = len_q;
    items1 = items_q;
    pws1 = pws_q;
    if (pulse_end) begin
      if (!fo_q) begin
        fo1 = 1'b1;
        bits1 = '0;
        len1 = '0;
        items1 = '0;
        pws1 = 1'b0;
      end
      if (count >= cfg_i.min_pulse_ms && len1 < LEN_W'(ELEM_CAP)) begin
        if (count >= cfg_i.dot_dash_limit_ms) begin
          bits1 = bits1 | (ELEM_W'(1) << len1);
        end
        len1 = len1 + 1'b1;
      end
    end
  end

  // A classified gap and the quiet-line timeout never fire on the same sample,
  // so one flush path serves both.
  assign gap_fire = gap_end & fo_q & (count >= cfg_i.element_gap_max_ms);
  assign end_fire = fo1 & line_high_i & (since1 >= cfg_i.frame_end_ms);
  assign flush_on = gap_fire | end_fire;
  assign add_space = gap_fire & (count >= cfg_i.word_gap_limit_ms)
                   & (count < cfg_i.frame_end_ms);
  assign do_end = end_fire | (gap_fire & (count >= cfg_i.word_gap_limit_ms)
                & (count >= cfg_i.frame_end_ms));

  assign let_em = flush_on & (len1 != '0) & (items1 < ITEMS_W'(FRAME_CAPACITY));
  assign items2 = items1 + ITEMS_W'(let_em);
  assign pws2 = let_em ? 1'b0 : pws1;
  assign sp_em = add_space & (items2 != '0) & ~pws2
               & (items2 < ITEMS_W'(FRAME_CAPACITY));
  assign items3 = items2 + ITEMS_W'(sp_em);
  assign pws3 = sp_em | pws2;
  assign end_em = do_end & (items3 != '0);

  always_comb begin
    letter_r.kind = KIND_LETTER;
    letter_r.bits = bits1;
    letter_r.len = len1;
    second_r.kind = sp_em ? KIND_SPACE : KIND_END;
    second_r.bits = '0;
    second_r.len = '0;
    entry_o.cnt = RES_CNT_W'(let_em) + RES_CNT_W'(sp_em) + RES_CNT_W'(end_em);
    entry_o.res0 = let_em ? letter_r : second_r;
    entry_o.res1 = second_r;
  end

  assign wr_o = accept_i & (let_em | sp_em | end_em);

  always_comb begin
    prev_d = prev_q;
    since_d = since_q;
    fo_d = fo_q;
    bits_d = bits_q;
    len_d = len_q;
    items_d = items_q;
    pws_d = pws_q;
    if (accept_i) begin
      prev_d = line_high_i;
      since_d = since1;
      if (do_end) begin
        fo_d = 1'b0;
        bits_d = '0;
        len_d = '0;
        items_d = '0;
        pws_d = 1'b0;
      end else if (flush_on) begin
        fo_d = fo1;
        bits_d = '0;
        len_d = '0;
        items_d = items3;
        pws_d = pws3;
      end else begin
        fo_d = fo1;
        bits_d = bits1;
        len_d = len1;
        items_d = items1;
        pws_d = pws1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b1;
      since_q <= '0;
      fo_q <= 1'b0;
      bits_q <= '0;
      len_q <= '0;
      items_q <= '0;
      pws_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      since_q <= since_d;
      fo_q <= fo_d;
      bits_q <= bits_d;
      len_q <= len_d;
      items_q <= items_d;
      pws_q <= pws_d;
    end
  end

`ifndef SYNTHESIS
  a_items_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= ITEMS_W'(FRAME_CAPACITY))
    else $error("frame item count above capacity");
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(ELEM_CAP))
    else $error("letter longer than element limit");
  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fo_q |-> (len_q == '0 && items_q == '0))
    else $error("letter or items held while no frame is open");
`endif

endmodule

@@ design/mpgr_fifo.sv @@
// Short queue of per-sample result entries between front and back ends.
// Depends on mpgr_pkg.
`timescale 1ns / 1ps

module mpgr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  mpgr_pkg::entry_t wdata_i,
  input  logic             rd_i,
  output mpgr_pkg::entry_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import mpgr_pkg::*;

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr = wr_i & ~full_o;
  assign do_rd = rd_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + (PTR_W + 1)'(do_wr) - (PTR_W + 1)'(do_rd);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> (count_q == $past(count_q) || count_q == $past(count_q) - 1'b1))
    else $error("queue written while full");
`endif

endmodule

@@ design/mpgr_back.sv @@
// Back end: hands the words of each queued entry out one at a time and
// marks the final word of a sample. Depends on mpgr_pkg.
`timescale 1ns / 1ps

module mpgr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mpgr_pkg::entry_t            head_i,
  input  logic                        fifo_empty_i,
  output logic                        rd_o,
  input  logic                        pop,
  output logic                        empty,
  output logic [1:0]                  kind_o,
  output logic [mpgr_pkg::ELEM_W-1:0] pattern_bits_o,
  output logic [mpgr_pkg::LEN_W-1:0]  pattern_len_o,
  output logic                        last_o
);
  import mpgr_pkg::*;

  logic    sub_q, sub_d;
  logic    pop_acc, two_words;
  result_t cur;

  assign two_words = (head_i.cnt == RES_CNT_W'(2));
  assign pop_acc = pop & ~fifo_empty_i;
  assign cur = sub_q ? head_i.res1 : head_i.res0;

  assign empty = fifo_empty_i;
  assign kind_o = cur.kind;
  assign pattern_bits_o = cur.bits;
  assign pattern_len_o = cur.len;
  assign last_o = sub_q | ~two_words;

  // The entry leaves the queue only once its final word is taken.
  assign rd_o = pop_acc & (sub_q | ~two_words);
  assign sub_d = pop_acc ? (~sub_q & two_words) : sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

`ifndef SYNTHESIS
  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_empty_i |-> head_i.cnt != '0)
    else $error("queued entry carries no word");
  a_second_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (!fifo_empty_i && two_words))
    else $error("second word selected without a two-word entry");
`endif

endmodule
